[hw/rtl/hbcd_pkg.sv]
`default_nettype none
package hbcd_pkg;

	localparam int ENTRIES  = 32;
	localparam int BUCKETS  = 13;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int BKT_W    = 4;
	localparam int RANK_W   = 5;
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 32;
	localparam int ID_W     = 5;
	localparam int HOLD_W   = 8;
	localparam logic [HOLD_W-1:0] HOLD_MAX = 8'hFF;

	localparam int PER_BKT  = ENTRIES / BUCKETS;
	localparam int LEFTOVER = ENTRIES % BUCKETS;
	localparam int PER_DIV  = (PER_BKT > 0) ? PER_BKT : 1;
	localparam int FULL_CNT = PER_BKT * BUCKETS;

	typedef enum logic [1:0] {
		FN_GET     = 2'd0,
		FN_RELEASE = 2'd1,
		FN_PIN     = 2'd2,
		FN_UNPIN   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NO_FREE = 2'd1,
		STS_ZERO    = 2'd2,
		STS_MAX     = 2'd3
	} status_t;

	function automatic logic [BKT_W-1:0] reset_bucket(input int e);
		int b;
		if (e < FULL_CNT) b = e / PER_DIV;
		else b = e - FULL_CNT;
		return BKT_W'(b);
	endfunction

	function automatic logic [RANK_W-1:0] reset_rank(input int e);
		int b;
		int pos;
		int cnt;
		if (e < FULL_CNT) begin
			b   = e / PER_DIV;
			pos = e - b * PER_BKT;
			cnt = PER_BKT + ((b < LEFTOVER) ? 1 : 0);
		end else begin
			pos = PER_BKT;
			cnt = PER_BKT + 1;
		end
		return RANK_W'(cnt - 1 - pos);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/hbcd_if.sv]
`default_nettype none
interface hbcd_req_if import hbcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       func;
	logic [DEV_W-1:0] device;
	logic [BLK_W-1:0] block_number;
	logic [ID_W-1:0]  entry_id;

	modport source (output valid, func, device, block_number, entry_id, input ready);
	modport sink   (input valid, func, device, block_number, entry_id, output ready);
endinterface

interface hbcd_rsp_if import hbcd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] entry_out;
	logic            hit;
	logic            needs_fill;
	logic [1:0]      status;

	modport source (output valid, entry_out, hit, needs_fill, status, input ready);
	modport sink   (input valid, entry_out, hit, needs_fill, status, output ready);
endinterface
`default_nettype wire

[hw/rtl/hbcd_mod_unit.sv]
`default_nettype none
module hbcd_mod_unit import hbcd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [BLK_W-1:0] operand,
	output logic                  done,
	output logic [BKT_W-1:0]      rem
);

	localparam int NIBBLES = BLK_W / 4;
	localparam int CNT_W   = $clog2(NIBBLES);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [BLK_W-1:0]     shift_q;
	logic [BKT_W-1:0]     rem_q;
	logic [BKT_W-1:0]     rem_next;

	always_comb begin
		logic [BKT_W+3:0] t;
		t = {rem_q, shift_q[BLK_W-1 -: 4]};
		for (int s = 3; s >= 0; s--) begin
			if (t >= ((BKT_W+4)'(BUCKETS) << s)) t = t - ((BKT_W+4)'(BUCKETS) << s);
		end
		rem_next = t[BKT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				shift_q <= operand;
				rem_q   <= '0;
			end else if (busy_q) begin
				rem_q   <= rem_next;
				shift_q <= shift_q << 4;
				cnt_q   <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NIBBLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

[hw/rtl/hashed_buffer_cache_directory.sv]
// Get: a reply on a hit or an in-bucket grant, on a grant whose entry moves to another
// bucket (which adds a second entry sweep to adjust ranks), or when no entry is free.
// Release, pin and unpin act on the hold count of the named entry and then reply.
// The remainder unit (eight nibble steps) and the entry sweeps (one entry per cycle) do
// the work; one item is in work at a time, and a stalled reply holds off the next grant.
// Reset (arst_n low) clears tags, valid bits, hold counts and loads the bucket layout at once.
`default_nettype none
module hashed_buffer_cache_directory import hbcd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hbcd_req_if.sink    req,
	hbcd_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		S_IDLE, S_MOD, S_SCAN, S_PICK, S_HIT, S_MOVE, S_RETAG, S_HOLD
	} state_t;

	typedef enum logic {
		F_WORK, F_FIN
	} fin_t;

	state_t              state_q;
	fin_t                fin_q;

	logic [DEV_W-1:0]    tag_dev_q   [ENTRIES];
	logic [BLK_W-1:0]    tag_blk_q   [ENTRIES];
	logic                valid_q     [ENTRIES];
	logic [HOLD_W-1:0]   hold_q      [ENTRIES];
	logic [BKT_W-1:0]    bucket_q    [ENTRIES];
	logic [RANK_W-1:0]   rank_q      [ENTRIES];

	func_t               func_q;
	logic [DEV_W-1:0]    dev_q;
	logic [BLK_W-1:0]    blk_q;
	logic [ID_W-1:0]     id_q;
	logic [BKT_W-1:0]    home_q;
	logic [IDX_W-1:0]    k_q;

	logic                hit_f_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [RANK_W-1:0]   hit_rank_q;
	logic                free_f_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [BKT_W-1:0]    free_bkt_q;
	logic [BKT_W-1:0]    free_d_q;
	logic [RANK_W-1:0]   free_rank_q;

	logic [ID_W-1:0]     res_eo_q;
	logic                res_hit_q;
	logic                res_fill_q;
	status_t             res_sts_q;

	logic                out_valid_q;
	logic [ID_W-1:0]     out_eo_q;
	logic                out_hit_q;
	logic                out_fill_q;
	status_t             out_sts_q;

	logic                mod_start;
	logic                mod_done;
	logic [BKT_W-1:0]    mod_rem;

	logic                accept;
	logic                out_free;
	logic                last_k;
	logic [BKT_W-1:0]    bkt_k;
	logic [RANK_W-1:0]   rank_k;
	logic [HOLD_W-1:0]   hold_k;
	logic [BKT_W:0]      dist_w;
	logic [BKT_W-1:0]    dist_k;
	logic                hit_cand;
	logic                free_cand;
	logic                id_in_range;

	assign accept      = req.valid && req.ready;
	assign req.ready   = (state_q == S_IDLE) && (fin_q == F_WORK);
	assign out_free    = !out_valid_q || rsp.ready;
	assign mod_start   = accept && (func_t'(req.func) == FN_GET);
	assign id_in_range = {1'b0, req.entry_id} < (ID_W+1)'(ENTRIES);

	assign last_k = (k_q == IDX_W'(ENTRIES - 1));
	assign bkt_k  = bucket_q[k_q];
	assign rank_k = rank_q[k_q];
	assign hold_k = hold_q[k_q];
	assign dist_w = {1'b0, bkt_k} + ((bkt_k < home_q) ? (BKT_W+1)'(BUCKETS) : '0)
		- {1'b0, home_q};
	assign dist_k = dist_w[BKT_W-1:0];

	assign hit_cand = (bkt_k == home_q) && (tag_dev_q[k_q] == dev_q) &&
		(tag_blk_q[k_q] == blk_q) && (!hit_f_q || (rank_k < hit_rank_q));
	assign free_cand = (hold_k == '0) &&
		(!free_f_q || ({dist_k, rank_k} < {free_d_q, free_rank_q}));

	hbcd_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.operand (req.block_number),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fin_q       <= F_WORK;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				tag_dev_q[i] <= '0;
				tag_blk_q[i] <= '0;
				valid_q[i]   <= 1'b0;
				hold_q[i]    <= '0;
				bucket_q[i]  <= reset_bucket(i);
				rank_q[i]    <= reset_rank(i);
			end
		end else begin
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			if (fin_q == F_FIN && out_free) begin
				out_valid_q <= 1'b1;
				out_eo_q    <= res_eo_q;
				out_hit_q   <= res_hit_q;
				out_fill_q  <= res_fill_q;
				out_sts_q   <= res_sts_q;
				fin_q       <= F_WORK;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= func_t'(req.func);
						dev_q  <= req.device;
						blk_q  <= req.block_number;
						id_q   <= req.entry_id;
						if (func_t'(req.func) == FN_GET) begin
							state_q <= S_MOD;
						end else if (id_in_range) begin
							k_q     <= req.entry_id[IDX_W-1:0];
							state_q <= S_HOLD;
						end else begin
							res_eo_q   <= req.entry_id;
							res_hit_q  <= 1'b0;
							res_fill_q <= 1'b0;
							res_sts_q  <= STS_ZERO;
							fin_q      <= F_FIN;
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						home_q   <= mod_rem;
						k_q      <= '0;
						hit_f_q  <= 1'b0;
						free_f_q <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit_cand) begin
						hit_f_q    <= 1'b1;
						hit_idx_q  <= k_q;
						hit_rank_q <= rank_k;
					end
					if (free_cand) begin
						free_f_q    <= 1'b1;
						free_idx_q  <= k_q;
						free_bkt_q  <= bkt_k;
						free_d_q    <= dist_k;
						free_rank_q <= rank_k;
					end
					k_q <= k_q + 1'b1;
					if (last_k) state_q <= S_PICK;
				end
				S_PICK: begin
					if (hit_f_q) begin
						k_q     <= hit_idx_q;
						state_q <= S_HIT;
					end else if (free_f_q) begin
						if (free_bkt_q != home_q) begin
							k_q     <= '0;
							state_q <= S_MOVE;
						end else begin
							k_q     <= free_idx_q;
							state_q <= S_RETAG;
						end
					end else begin
						res_eo_q   <= '0;
						res_hit_q  <= 1'b0;
						res_fill_q <= 1'b0;
						res_sts_q  <= STS_NO_FREE;
						fin_q      <= F_FIN;
						state_q    <= S_IDLE;
					end
				end
				S_HIT: begin
					res_eo_q  <= ID_W'(k_q);
					res_hit_q <= 1'b1;
					if (hold_k == HOLD_MAX) begin
						res_fill_q <= 1'b0;
						res_sts_q  <= STS_MAX;
					end else begin
						hold_q[k_q]  <= hold_k + 1'b1;
						valid_q[k_q] <= 1'b1;
						res_fill_q   <= !valid_q[k_q];
						res_sts_q    <= STS_OK;
					end
					fin_q   <= F_FIN;
					state_q <= S_IDLE;
				end
				S_MOVE: begin
					if (k_q != free_idx_q) begin
						if (bkt_k == free_bkt_q && rank_k > free_rank_q)
							rank_q[k_q] <= rank_k - 1'b1;
						else if (bkt_k == home_q)
							rank_q[k_q] <= rank_k + 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (last_k) begin
						k_q     <= free_idx_q;
						state_q <= S_RETAG;
					end
				end
				S_RETAG: begin
					tag_dev_q[k_q] <= dev_q;
					tag_blk_q[k_q] <= blk_q;
					hold_q[k_q]    <= HOLD_W'(1);
					valid_q[k_q]   <= 1'b1;
					if (free_bkt_q != home_q) begin
						bucket_q[k_q] <= home_q;
						rank_q[k_q]   <= '0;
					end
					res_eo_q   <= ID_W'(k_q);
					res_hit_q  <= 1'b0;
					res_fill_q <= 1'b1;
					res_sts_q  <= STS_OK;
					fin_q      <= F_FIN;
					state_q    <= S_IDLE;
				end
				S_HOLD: begin
					res_eo_q   <= id_q;
					res_hit_q  <= 1'b0;
					res_fill_q <= 1'b0;
					if (hold_k == '0) begin
						res_sts_q <= STS_ZERO;
					end else if (func_q == FN_PIN) begin
						if (hold_k == HOLD_MAX) begin
							res_sts_q <= STS_MAX;
						end else begin
							hold_q[k_q] <= hold_k + 1'b1;
							res_sts_q   <= STS_OK;
						end
					end else begin
						hold_q[k_q] <= hold_k - 1'b1;
						res_sts_q   <= STS_OK;
					end
					fin_q   <= F_FIN;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.entry_out  = out_eo_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.needs_fill = out_fill_q;
	assign rsp.status     = out_sts_q;

endmodule
`default_nettype wire
